// ===== design/rgbm_pkg.sv =====
// Package for the RGBM HDR color encoder: fixed-point constants, stage counts,
// and the one-step square-root and division helpers used by the pipeline.
// Depends on nothing.
package rgbm_pkg;

	localparam int CH_W     = 24;
	localparam int Q_W      = 20;
	localparam int REM_W    = 22;
	localparam int RAD_W    = 40;
	localparam int DIV_W    = 48;
	localparam int SQ_STEPS = 20;
	localparam int T_STEPS  = 20;
	localparam int C_STEPS  = 20;
	localparam int B_STEPS  = 9;
	localparam int NCH      = 3;

	localparam logic [Q_W-1:0]   THRESH_075  = 20'd786432;
	localparam logic [DIV_W-1:0] CONST_05625 = 48'd589824;
	localparam logic [DIV_W-1:0] CONST_05    = 48'd524288;
	localparam logic [27:0]      CEIL_BIAS   = 28'd1048575;
	localparam logic [16:0]      TWICE_65025 = 17'd130050;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   root;
	} sq_step_t;

	typedef struct packed {
		logic [DIV_W-1:0] r;
		logic             hit;
	} div_step_t;

	// One digit of the restoring square root: two radicand bits in, one root bit out.
	function automatic sq_step_t sqrt_step(input logic [REM_W-1:0] rem,
		input logic [Q_W-1:0] root, input logic [1:0] pair);
		sq_step_t     res;
		logic [23:0]  acc;
		logic [23:0]  trial;
		acc   = {rem, pair};
		trial = {2'b00, root, 2'b01};
		if (acc >= trial) begin
			res.rem  = REM_W'(acc - trial);
			res.root = {root[Q_W-2:0], 1'b1};
		end else begin
			res.rem  = acc[REM_W-1:0];
			res.root = {root[Q_W-2:0], 1'b0};
		end
		return res;
	endfunction

	// One quotient bit of a restoring division against a pre-shifted divisor.
	function automatic div_step_t div_step(input logic [DIV_W-1:0] r,
		input logic [DIV_W-1:0] ds);
		div_step_t res;
		res.hit = (r >= ds);
		res.r   = res.hit ? (r - ds) : r;
		return res;
	endfunction

endpackage

// ===== design/rgbm_hdr_color_encoder.sv =====
// RGBM HDR color encoder: linear Q0.24 color in, RGBM bytes out.
// Throughput is one beat per cycle while the output is not stalled; the rate is
// set by the one-digit-per-stage square root and division pipelines, which all
// advance together. A stalled output holds the whole pipeline, so no beat is
// lost or repeated.
// Reset (arst_n low) clears only the stage valid bits; data registers keep garbage.
module rgbm_hdr_color_encoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rgbm_pkg::CH_W-1:0] red_in,
	input  logic [rgbm_pkg::CH_W-1:0] green_in,
	input  logic [rgbm_pkg::CH_W-1:0] blue_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                red_out,
	output logic [7:0]                green_out,
	output logic [7:0]                blue_out,
	output logic [7:0]                multiplier_out
);
	import rgbm_pkg::*;

	// The pipeline moves as one: it advances unless a finished beat sits unread.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic [CH_W-1:0] ch_in [NCH];
	assign ch_in[0] = red_in;
	assign ch_in[1] = green_in;
	assign ch_in[2] = blue_in;

	// Valid bits, one per stage of each section.
	logic [SQ_STEPS-1:0] v_s1;
	logic                v_s2;
	logic [T_STEPS-1:0]  v_s3;
	logic                v_s4;
	logic [C_STEPS-1:0]  v_s5;
	logic                v_s6;
	logic [B_STEPS-1:0]  v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= '0;
			v_s2 <= 1'b0;
			v_s3 <= '0;
			v_s4 <= 1'b0;
			v_s5 <= '0;
			v_s6 <= 1'b0;
			v_s7 <= '0;
		end else if (en) begin
			v_s1 <= {v_s1[SQ_STEPS-2:0], in_valid};
			v_s2 <= v_s1[SQ_STEPS-1];
			v_s3 <= {v_s3[T_STEPS-2:0], v_s2};
			v_s4 <= v_s3[T_STEPS-1];
			v_s5 <= {v_s5[C_STEPS-2:0], v_s4};
			v_s6 <= v_s5[C_STEPS-1];
			v_s7 <= {v_s7[B_STEPS-2:0], v_s6};
		end
	end

	// Section 1: gamma step. Each channel's sqrt of X * 2^16 is found one root bit
	// per stage; the radicand shifts left two bits at a time.
	logic [RAD_W-1:0] x_s1    [SQ_STEPS][NCH];
	logic [REM_W-1:0] rem_s1  [SQ_STEPS][NCH];
	logic [Q_W-1:0]   root_s1 [SQ_STEPS][NCH];

	always_ff @(posedge clk) begin
		sq_step_t st;
		if (en) begin
			for (int j = 0; j < NCH; j++) begin
				st = sqrt_step('0, '0, ch_in[j][CH_W-1:CH_W-2]);
				x_s1[0][j]    <= {ch_in[j][CH_W-3:0], 18'd0};
				rem_s1[0][j]  <= st.rem;
				root_s1[0][j] <= st.root;
			end
			for (int i = 1; i < SQ_STEPS; i++) begin
				for (int j = 0; j < NCH; j++) begin
					st = sqrt_step(rem_s1[i-1][j], root_s1[i-1][j],
						x_s1[i-1][j][RAD_W-1:RAD_W-2]);
					x_s1[i][j]    <= {x_s1[i-1][j][RAD_W-3:0], 2'b00};
					rem_s1[i][j]  <= st.rem;
					root_s1[i][j] <= st.root;
				end
			end
		end
	end

	// Section 2: the largest channel, floored at one LSB, and the test for the
	// compression knee at 0.75.
	logic [Q_W-1:0] mx_c;
	always_comb begin
		mx_c = 20'd1;
		for (int j = 0; j < NCH; j++) begin
			if (root_s1[SQ_STEPS-1][j] > mx_c) begin
				mx_c = root_s1[SQ_STEPS-1][j];
			end
		end
	end

	logic [Q_W-1:0] c_s2 [NCH];
	logic [Q_W-1:0] m_s2;
	logic           comp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NCH; j++) begin
				c_s2[j] <= root_s1[SQ_STEPS-1][j];
			end
			m_s2    <= mx_c;
			comp_s2 <= (mx_c > THRESH_075);
		end
	end

	// Section 3: compressed maximum T = round((m - 0.5625) / (m - 0.5)) in Q0.20,
	// one quotient bit per stage. Its value only matters when compressing.
	logic [DIV_W-1:0] tn_c;
	logic [DIV_W-1:0] td_c;
	assign tn_c = ((DIV_W'(m_s2) - CONST_05625) << 21) + (DIV_W'(m_s2) - CONST_05);
	assign td_c = (DIV_W'(m_s2) - CONST_05) << 1;

	logic [DIV_W-1:0] tr_s3 [T_STEPS];
	logic [DIV_W-1:0] td_s3 [T_STEPS];
	logic [Q_W-1:0]   tq_s3 [T_STEPS];
	logic [Q_W-1:0]   c_s3  [T_STEPS][NCH];
	logic [Q_W-1:0]   m_s3  [T_STEPS];
	logic             comp_s3 [T_STEPS];

	always_ff @(posedge clk) begin
		div_step_t ds;
		if (en) begin
			ds = div_step(tn_c, td_c << (T_STEPS-1));
			tr_s3[0]   <= ds.r;
			td_s3[0]   <= td_c;
			tq_s3[0]   <= {{(Q_W-1){1'b0}}, ds.hit};
			c_s3[0]    <= c_s2;
			m_s3[0]    <= m_s2;
			comp_s3[0] <= comp_s2;
			for (int k = 1; k < T_STEPS; k++) begin
				ds = div_step(tr_s3[k-1], td_s3[k-1] << (T_STEPS-1-k));
				tr_s3[k]   <= ds.r;
				td_s3[k]   <= td_s3[k-1];
				tq_s3[k]   <= {tq_s3[k-1][Q_W-2:0], ds.hit};
				c_s3[k]    <= c_s3[k-1];
				m_s3[k]    <= m_s3[k-1];
				comp_s3[k] <= comp_s3[k-1];
			end
		end
	end

	// Section 4: numerators 2*c*T + m for the channel rescale.
	logic [DIV_W-1:0] cn_s4 [NCH];
	logic [Q_W-1:0]   c_s4  [NCH];
	logic [Q_W-1:0]   m_s4;
	logic [Q_W-1:0]   t_s4;
	logic             comp_s4;

	always_ff @(posedge clk) begin
		logic [39:0] p;
		if (en) begin
			for (int j = 0; j < NCH; j++) begin
				p = c_s3[T_STEPS-1][j] * tq_s3[T_STEPS-1];
				cn_s4[j] <= DIV_W'({p, 1'b0}) + DIV_W'(m_s3[T_STEPS-1]);
			end
			c_s4    <= c_s3[T_STEPS-1];
			m_s4    <= m_s3[T_STEPS-1];
			t_s4    <= tq_s3[T_STEPS-1];
			comp_s4 <= comp_s3[T_STEPS-1];
		end
	end

	// Section 5: rescaled channels round(c * T / m), one quotient bit per stage.
	logic [DIV_W-1:0] cd_c;
	assign cd_c = DIV_W'({m_s4, 1'b0});

	logic [DIV_W-1:0] cr_s5 [C_STEPS][NCH];
	logic [Q_W-1:0]   cq_s5 [C_STEPS][NCH];
	logic [DIV_W-1:0] cd_s5 [C_STEPS];
	logic [Q_W-1:0]   c_s5  [C_STEPS][NCH];
	logic [Q_W-1:0]   m_s5  [C_STEPS];
	logic [Q_W-1:0]   t_s5  [C_STEPS];
	logic             comp_s5 [C_STEPS];

	always_ff @(posedge clk) begin
		div_step_t ds;
		if (en) begin
			for (int j = 0; j < NCH; j++) begin
				ds = div_step(cn_s4[j], cd_c << (C_STEPS-1));
				cr_s5[0][j] <= ds.r;
				cq_s5[0][j] <= {{(Q_W-1){1'b0}}, ds.hit};
			end
			cd_s5[0]   <= cd_c;
			c_s5[0]    <= c_s4;
			m_s5[0]    <= m_s4;
			t_s5[0]    <= t_s4;
			comp_s5[0] <= comp_s4;
			for (int k = 1; k < C_STEPS; k++) begin
				for (int j = 0; j < NCH; j++) begin
					ds = div_step(cr_s5[k-1][j], cd_s5[k-1] << (C_STEPS-1-k));
					cr_s5[k][j] <= ds.r;
					cq_s5[k][j] <= {cq_s5[k-1][j][Q_W-2:0], ds.hit};
				end
				cd_s5[k]   <= cd_s5[k-1];
				c_s5[k]    <= c_s5[k-1];
				m_s5[k]    <= m_s5[k-1];
				t_s5[k]    <= t_s5[k-1];
				comp_s5[k] <= comp_s5[k-1];
			end
		end
	end

	// Section 6: pick the compressed or plain values, form the multiplier byte
	// ceil(m * 255 / 2^20), and the scaled color products 2 * c * 65025.
	logic [Q_W-1:0] mf_c;
	logic [27:0]    msum_c;
	logic [7:0]     mult_c;
	assign mf_c   = comp_s5[C_STEPS-1] ? t_s5[C_STEPS-1] : m_s5[C_STEPS-1];
	assign msum_c = (28'(mf_c) * 28'd255) + CEIL_BIAS;
	assign mult_c = (msum_c[27:20] == 8'd0) ? 8'd1 : msum_c[27:20];

	logic [36:0] cp_s6 [NCH];
	logic [7:0]  mult_s6;

	always_ff @(posedge clk) begin
		logic [Q_W-1:0] cf;
		if (en) begin
			for (int j = 0; j < NCH; j++) begin
				cf = comp_s5[C_STEPS-1] ? cq_s5[C_STEPS-1][j] : c_s5[C_STEPS-1][j];
				cp_s6[j] <= cf * TWICE_65025;
			end
			mult_s6 <= mult_c;
		end
	end

	// Section 7: color bytes round(c * 65025 / (M * 2^20)), one bit per stage.
	logic [DIV_W-1:0] bd_c;
	assign bd_c = DIV_W'({mult_s6, 21'd0});

	logic [DIV_W-1:0]   br_s7 [B_STEPS][NCH];
	logic [B_STEPS-1:0] bq_s7 [B_STEPS][NCH];
	logic [DIV_W-1:0]   bd_s7 [B_STEPS];
	logic [7:0]         mult_s7 [B_STEPS];

	always_ff @(posedge clk) begin
		div_step_t ds;
		if (en) begin
			for (int j = 0; j < NCH; j++) begin
				ds = div_step(DIV_W'(cp_s6[j]) + DIV_W'({mult_s6, 20'd0}),
					bd_c << (B_STEPS-1));
				br_s7[0][j] <= ds.r;
				bq_s7[0][j] <= {{(B_STEPS-1){1'b0}}, ds.hit};
			end
			bd_s7[0]   <= bd_c;
			mult_s7[0] <= mult_s6;
			for (int k = 1; k < B_STEPS; k++) begin
				for (int j = 0; j < NCH; j++) begin
					ds = div_step(br_s7[k-1][j], bd_s7[k-1] << (B_STEPS-1-k));
					br_s7[k][j] <= ds.r;
					bq_s7[k][j] <= {bq_s7[k-1][j][B_STEPS-2:0], ds.hit};
				end
				bd_s7[k]   <= bd_s7[k-1];
				mult_s7[k] <= mult_s7[k-1];
			end
		end
	end

	// The last stage is the output register; color bytes saturate at 255.
	logic [7:0] byte_c [NCH];
	always_comb begin
		for (int j = 0; j < NCH; j++) begin
			byte_c[j] = bq_s7[B_STEPS-1][j][B_STEPS-1] ? 8'd255
				: bq_s7[B_STEPS-1][j][7:0];
		end
	end

	assign out_valid      = v_s7[B_STEPS-1];
	assign red_out        = byte_c[0];
	assign green_out      = byte_c[1];
	assign blue_out       = byte_c[2];
	assign multiplier_out = mult_s7[B_STEPS-1];

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the RGBM HDR color encoder.
// Uses rgbm_pkg for the channel width; predicts each result in the bench.
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] mult;
	} rgbm_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [rgbm_pkg::CH_W-1:0] red_in = '0;
	logic [rgbm_pkg::CH_W-1:0] green_in = '0;
	logic [rgbm_pkg::CH_W-1:0] blue_in = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [7:0]                red_out;
	logic [7:0]                green_out;
	logic [7:0]                blue_out;
	logic [7:0]                multiplier_out;

	// Expected encodings, oldest first.
	rgbm_t pending_colors[$];
	int    errors = 0;
	int    beats_in = 0;
	int    beats_out = 0;
	int    send_idle_pct = 0;
	int    recv_idle_pct = 0;
	bit    hold_off = 1'b0;
	int    quiet_cycles = 0;

	localparam int LATENCY = 72;
	localparam int WATCHDOG_LIMIT = 20000;

	rgbm_hdr_color_encoder uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.multiplier_out(multiplier_out)
	);

	always #5 clk = ~clk;

	// Integer square root of a 40-bit radicand, one bit at a time.
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = '0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Full RGBM encoding of one linear color.
	function automatic rgbm_t encode_rgbm(input logic [23:0] rx, input logic [23:0] gx,
		input logic [23:0] bx);
		logic [63:0] ch[3];
		logic [63:0] peak;
		logic [63:0] tone;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] mult;
		logic [63:0] v[3];
		rgbm_t       res;
		ch[0] = int_sqrt({24'd0, rx, 16'd0});
		ch[1] = int_sqrt({24'd0, gx, 16'd0});
		ch[2] = int_sqrt({24'd0, bx, 16'd0});
		peak = 64'd1;
		for (int i = 0; i < 3; i++)
			if (ch[i] > peak)
				peak = ch[i];
		// Bright colors: the peak is compressed and the channels follow it.
		if (peak > 64'd786432) begin
			num  = (peak - 64'd589824) << 20;
			den  = peak - 64'd524288;
			tone = (2 * num + den) / (2 * den);
			for (int i = 0; i < 3; i++)
				ch[i] = (2 * ch[i] * tone + peak) / (2 * peak);
			peak = tone;
		end
		mult = (peak * 255 + 64'd1048575) >> 20;
		if (mult > 255)
			mult = 64'd255;
		if (mult == 0)
			mult = 64'd1;
		for (int i = 0; i < 3; i++) begin
			num  = ch[i] * 65025;
			den  = mult << 20;
			v[i] = (2 * num + den) / (2 * den);
			if (v[i] > 255)
				v[i] = 64'd255;
		end
		res.r    = v[0][7:0];
		res.g    = v[1][7:0];
		res.b    = v[2][7:0];
		res.mult = mult[7:0];
		return res;
	endfunction

	// Offers one color beat and waits until the block takes it. Valid stays high
	// after the beat so that the next call can follow without a gap.
	task automatic send_color(input logic [23:0] rx, input logic [23:0] gx,
		input logic [23:0] bx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red_in   <= rx;
		green_in <= gx;
		blue_in  <= bx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_colors.push_back(encode_rgbm(rx, gx, bx));
		beats_in++;
	endtask

	// Receiver ready: random stalls, or a long hold-off when asked.
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Result checker: compares every accepted output beat with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			rgbm_t got;
			rgbm_t want;
			got = '{red_out, green_out, blue_out, multiplier_out};
			beats_out++;
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected beat, actual %h", $time, got);
				errors++;
			end else begin
				want = pending_colors.pop_front();
				if (got.r != want.r)
					$display("%0t: red expected %0d actual %0d", $time, want.r, got.r);
				if (got.g != want.g)
					$display("%0t: green expected %0d actual %0d", $time, want.g, got.g);
				if (got.b != want.b)
					$display("%0t: blue expected %0d actual %0d", $time, want.b, got.b);
				if (got.mult != want.mult)
					$display("%0t: multiplier expected %0d actual %0d", $time,
						want.mult, got.mult);
				if (got != want)
					errors++;
			end
		end
	end

	// Watchdog: too many cycles without any beat moving ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Random channel value, biased toward the interesting ranges.
	function automatic logic [23:0] rand_channel();
		case ($urandom_range(5))
			0: return 24'($urandom_range(255));
			1: return 24'($urandom_range(24'hFFFF));
			2: return 24'(24'hFFFFFF - $urandom_range(255));
			3: return 24'(24'h090000 + $urandom_range(24'h0FFFFF));
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic test_directed();
		send_color(24'd0, 24'd0, 24'd0);          // all zero: multiplier floors at one
		send_color(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_color(24'hFFFFFF, 24'd0, 24'd0);
		send_color(24'd0, 24'hFFFFFF, 24'd0);
		send_color(24'd0, 24'd0, 24'hFFFFFF);
		send_color(24'd1, 24'd1, 24'd1);
		send_color(24'h010000, 24'h008000, 24'h000001);
		// Around the compression knee, where the gamma value crosses 0.75.
		send_color(24'h900000, 24'h100000, 24'h000000);
		send_color(24'h8FFFFF, 24'h000000, 24'h400000);
		send_color(24'h900001, 24'h900001, 24'h0000FF);
		send_color(24'hAAAAAA, 24'h555555, 24'h123456);
		send_color(24'h555555, 24'hAAAAAA, 24'hEDCBA9);
		send_color(24'h000100, 24'h000200, 24'h000400);
	endtask

	task automatic test_random(input int count);
		repeat (count)
			send_color(rand_channel(), rand_channel(), rand_channel());
	endtask

	// Receiver holds off while the sender keeps offering, so the pipe backs up.
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			test_random(120);
			begin
				repeat (300)
					@(posedge clk);
				hold_off = 1'b0;
			end
		join
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8)
			@(posedge clk);
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 18;
		recv_idle_pct = 56;
		test_directed();
		test_random(280);
		send_idle_pct = 56;
		recv_idle_pct = 18;
		test_random(280);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(160);
		test_backpressure();
		drain();
		$display("Sent %0d colors, checked %0d encoded beats under varied stalls,",
			beats_in, beats_out);
		$display("including the knee, extremes and a long output hold-off.");
		if (errors == 0 && pending_colors.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rgbm_pkg.sv
design/rgbm_hdr_color_encoder.sv
test/tb.sv
